### hw/rtl/rcp_pkg.sv
// Shared types and constants for the RESP command parser.
`default_nettype none

package rcp_pkg;

	// Width of a bulk length; the number accumulator carries one extra bit to saturate
	localparam int LENGTH_BITS = 32;
	localparam int ACC_W       = LENGTH_BITS + 1;
	localparam int CMP_W       = (ACC_W > 32) ? ACC_W : 32;
	localparam int PROD_W      = ACC_W + 4;

	// Configuration register indexes and reset values
	localparam logic CFG_MAX_ELEMENTS    = 1'b0;
	localparam logic CFG_MAX_BULK_LENGTH = 1'b1;
	localparam logic [15:0] MAX_ELEMENTS_RST    = 16'd1024;
	localparam logic [31:0] MAX_BULK_LENGTH_RST = 32'd536870912;

	// Framing characters
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Result kinds
	localparam logic [1:0] KIND_FRAME   = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_INVALID = 2'd2;

	typedef struct packed {
		logic [15:0] max_elements;
		logic [31:0] max_bulk_length;
	} rcp_cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  payload_byte;
		logic [15:0] element_index;
		logic        element_done;
		logic        command_done;
		logic [15:0] element_total;
	} rcp_result_t;

endpackage

`default_nettype wire

### hw/rtl/resp_command_parser_unit.sv
// Top level of the RESP command parser: ports, configuration and input register.
//
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_ready    in_byte
// out       out  out_valid / out_ready  kind, payload_byte, element_index,
//                                       element_done, command_done, element_total
// cfg       in   cfg_we                 cfg_index, cfg_wdata
//
// One byte per cycle sustained while out is not stalled; each byte gives one result,
// passing the input register, then the parser state update into the result register.
// Reset clears the parser to wait for '*' and loads the configuration defaults.
// A stall on out holds the result register; in_ready drops only when both the input
// register and the result register are full and out_ready is low.
`default_nettype none

module resp_command_parser_unit
	import rcp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       payload_byte,
	output logic [15:0]      element_index,
	output logic             element_done,
	output logic             command_done,
	output logic [15:0]      element_total,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	rcp_cfg_t    cfg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        take;
	rcp_result_t res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_elements    <= MAX_ELEMENTS_RST;
			cfg_q.max_bulk_length <= MAX_BULK_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_ELEMENTS:    cfg_q.max_elements    <= cfg_wdata[15:0];
				CFG_MAX_BULK_LENGTH: cfg_q.max_bulk_length <= cfg_wdata;
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	// Input register: accept a beat when empty or when its beat moves on
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	rcp_parse_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (valid_s1),
		.byte_data  (byte_s1),
		.take       (take),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res        (res)
	);

	assign kind          = res.kind;
	assign payload_byte  = res.payload_byte;
	assign element_index = res.element_index;
	assign element_done  = res.element_done;
	assign command_done  = res.command_done;
	assign element_total = res.element_total;

	// An input beat moves into the parser whenever the result register is empty
	a_input_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid |-> take)
		else $error("input beat held while the result register is empty");

	// Input register never refills while its beat is stuck
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take |-> !in_ready)
		else $error("input register overwritten");

	// A parsed beat always yields a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid)
		else $error("parsed beat without a result");

endmodule

`default_nettype wire

### hw/rtl/rcp_parse_fsm.sv
// Parser state machine with its result register.
`default_nettype none

module rcp_parse_fsm
	import rcp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rcp_cfg_t    cfg,
	input  wire logic        byte_valid,
	input  wire logic [7:0]  byte_data,
	output logic             take,
	output logic             res_valid,
	input  wire logic        res_ready,
	output rcp_result_t      res
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RESYNC,
		PH_CNT_NUM,
		PH_CNT_LF,
		PH_DOLLAR,
		PH_LEN_NUM,
		PH_LEN_LF,
		PH_PAYLOAD,
		PH_DATA_CR,
		PH_DATA_LF
	} phase_t;

	phase_t                   phase_q, phase_d;
	logic                     minus_q, minus_d;
	logic                     digit_q, digit_d;
	logic [ACC_W-1:0]         acc_q, acc_d;
	logic [15:0]              cnt_q, cnt_d;
	logic [15:0]              elem_q, elem_d;
	logic [LENGTH_BITS-1:0]   left_q, left_d;
	logic                     res_valid_q;
	rcp_result_t              res_q, res_d;

	logic                     is_digit;
	logic [3:0]               digit_val;
	logic [PROD_W-1:0]        prod;
	logic [PROD_W-1:0]        cap_ext;
	logic [ACC_W-1:0]         acc_step;
	logic [ACC_W-1:0]         cap;
	logic [CMP_W-1:0]         acc_cmp;
	logic [CMP_W-1:0]         max_bulk_cmp;
	logic [ACC_W-1:0]         max_elem_ext;
	logic [15:0]              elem_inc;
	logic                     bad;
	logic                     num_err;
	logic                     neg_value;

	// Move a beat when the result register is free or being drained
	assign take = byte_valid && (!res_valid_q || res_ready);

	// Decimal accumulate, saturating at the length cap
	assign cap       = {1'b1, {LENGTH_BITS{1'b0}}};
	assign cap_ext   = {4'd0, cap};
	assign is_digit  = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
	assign digit_val = 4'(byte_data - CH_ZERO);
	assign prod      = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {{(PROD_W-4){1'b0}}, digit_val};
	assign acc_step  = (prod > cap_ext) ? cap : prod[ACC_W-1:0];

	assign acc_cmp      = CMP_W'(acc_q);
	assign max_bulk_cmp = CMP_W'(cfg.max_bulk_length);
	assign max_elem_ext = ACC_W'(cfg.max_elements);
	assign elem_inc     = elem_q + 16'd1;
	assign neg_value    = minus_q && (acc_q != '0);

	// Next state and result for the beat in hand
	always_comb begin
		phase_d = phase_q;
		minus_d = minus_q;
		digit_d = digit_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		elem_d  = elem_q;
		left_d  = left_q;
		bad     = 1'b0;
		num_err = 1'b0;
		res_d   = '0;
		res_d.kind          = KIND_FRAME;
		res_d.element_index = elem_q;

		// Number body shared by count and length lines
		if (is_digit) begin
			acc_d   = acc_step;
			digit_d = 1'b1;
		end else if (byte_data == CH_MINUS && !minus_q && !digit_q) begin
			minus_d = 1'b1;
		end else if (!(byte_data == CH_CR && digit_q)) begin
			num_err = 1'b1;
		end

		unique case (phase_q)
			PH_IDLE, PH_RESYNC: begin
				minus_d = minus_q;
				digit_d = digit_q;
				acc_d   = acc_q;
				res_d.element_index = '0;
				if (byte_data == CH_STAR) begin
					minus_d = 1'b0;
					digit_d = 1'b0;
					acc_d   = '0;
					cnt_d   = '0;
					elem_d  = '0;
					phase_d = PH_CNT_NUM;
				end else if (phase_q == PH_IDLE) begin
					bad = 1'b1;
				end
			end
			PH_CNT_NUM: begin
				bad = num_err;
				if (!is_digit && byte_data == CH_CR && digit_q) begin
					phase_d = PH_CNT_LF;
				end
			end
			PH_LEN_NUM: begin
				bad = num_err;
				if (!is_digit && byte_data == CH_CR && digit_q) begin
					phase_d = PH_LEN_LF;
				end
			end
			PH_CNT_LF: begin
				minus_d = 1'b0;
				digit_d = 1'b0;
				acc_d   = '0;
				if (byte_data != CH_LF || neg_value || acc_q > max_elem_ext) begin
					bad = 1'b1;
				end else begin
					cnt_d  = acc_q[15:0];
					elem_d = '0;
					if (acc_q == '0) begin
						res_d.command_done = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_DOLLAR;
					end
				end
			end
			PH_DOLLAR: begin
				minus_d = 1'b0;
				digit_d = 1'b0;
				acc_d   = '0;
				if (byte_data != CH_DOLLAR) begin
					bad = 1'b1;
				end else begin
					phase_d = PH_LEN_NUM;
				end
			end
			PH_LEN_LF: begin
				minus_d = 1'b0;
				digit_d = 1'b0;
				acc_d   = '0;
				if (byte_data != CH_LF || neg_value || acc_cmp > max_bulk_cmp ||
						acc_q[ACC_W-1]) begin
					bad = 1'b1;
				end else begin
					left_d  = acc_q[LENGTH_BITS-1:0];
					phase_d = (acc_q == '0) ? PH_DATA_CR : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				minus_d = minus_q;
				digit_d = digit_q;
				acc_d   = acc_q;
				res_d.kind         = KIND_PAYLOAD;
				res_d.payload_byte = byte_data;
				left_d = left_q - LENGTH_BITS'(1);
				if (left_q == LENGTH_BITS'(1)) begin
					phase_d = PH_DATA_CR;
				end
			end
			PH_DATA_CR: begin
				minus_d = minus_q;
				digit_d = digit_q;
				acc_d   = acc_q;
				if (byte_data != CH_CR) begin
					bad = 1'b1;
				end else begin
					phase_d = PH_DATA_LF;
				end
			end
			PH_DATA_LF: begin
				minus_d = minus_q;
				digit_d = digit_q;
				acc_d   = acc_q;
				if (byte_data != CH_LF) begin
					bad = 1'b1;
				end else begin
					res_d.element_done = 1'b1;
					elem_d = elem_inc;
					if (elem_inc == cnt_q) begin
						res_d.command_done = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_DOLLAR;
					end
				end
			end
			default: begin
				bad = 1'b1;
			end
		endcase

		// Drop the command and resync on any framing error
		if (bad) begin
			minus_d = 1'b0;
			digit_d = 1'b0;
			acc_d   = '0;
			cnt_d   = '0;
			elem_d  = '0;
			left_d  = '0;
			phase_d = PH_RESYNC;
			res_d   = '0;
			res_d.kind = KIND_INVALID;
		end else begin
			res_d.element_total = cnt_d;
		end
	end

	// Hold state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			minus_q     <= 1'b0;
			digit_q     <= 1'b0;
			acc_q       <= '0;
			cnt_q       <= '0;
			elem_q      <= '0;
			left_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				minus_q <= minus_d;
				digit_q <= digit_d;
				acc_q   <= acc_d;
				cnt_q   <= cnt_d;
				elem_q  <= elem_d;
				left_q  <= left_d;
				res_q   <= res_d;
			end
			if (take) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// An invalid result carries nothing but its kind
	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.kind == KIND_INVALID |->
		res_q.payload_byte == '0 && res_q.element_index == '0 &&
		!res_q.element_done && !res_q.command_done && res_q.element_total == '0)
		else $error("invalid result with non-zero fields");

	// Done marks appear only on framing bytes
	a_done_on_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.element_done || res_q.command_done) |->
		res_q.kind == KIND_FRAME)
		else $error("done mark on a non-framing result");

	// Payload phase always has bytes left
	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> left_q != '0)
		else $error("payload phase with no bytes left");

	// An element index stays below the declared total inside a command
	a_elem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DOLLAR || phase_q == PH_PAYLOAD || phase_q == PH_DATA_CR ||
		 phase_q == PH_DATA_LF) |-> elem_q < cnt_q)
		else $error("element index past the declared count");

endmodule

`default_nettype wire

### tb/resp_command_parser_unit_tb.sv
// Self-checking testbench for the RESP command parser: byte stream in, checked results out.

import rcp_pkg::*;

// Saturation point of the number accumulator
localparam logic [63:0] LEN_CAP = 64'd1 << LENGTH_BITS;

// Parser position inside a command, as the predictor tracks it
typedef enum logic [3:0] {
	ST_WAIT_STAR,
	ST_SKIP,
	ST_COUNT,
	ST_COUNT_LF,
	ST_MARKER,
	ST_LENGTH,
	ST_LENGTH_LF,
	ST_DATA,
	ST_TAIL_CR,
	ST_TAIL_LF
} parse_state_e;

// Receiver stall styles
typedef enum logic [1:0] {
	RX_OPEN,
	RX_COIN,
	RX_SPARSE,
	RX_PERIODIC
} ready_style_e;

class resp_result_board;
	rcp_result_t owed_results[$];
	int errors;

	// Limits as last written
	logic [15:0] lim_elems;
	logic [31:0] lim_bulk;

	// Parser state
	parse_state_e state;
	bit neg_sign;
	bit have_digit;
	logic [63:0] value_acc;
	logic [15:0] elem_count;
	logic [15:0] elem_pos;
	logic [63:0] bytes_left;

	function new();
		errors = 0;
		lim_elems = MAX_ELEMENTS_RST;
		lim_bulk = MAX_BULK_LENGTH_RST;
		state = ST_WAIT_STAR;
		clear_number();
		elem_count = '0;
		elem_pos = '0;
		bytes_left = '0;
	endfunction

	function void set_register(logic idx, logic [31:0] val);
		if (idx == CFG_MAX_ELEMENTS) begin
			lim_elems = val[15:0];
		end else begin
			lim_bulk = val;
		end
	endfunction

	function void clear_number();
		neg_sign = 1'b0;
		have_digit = 1'b0;
		value_acc = '0;
	endfunction

	// Consume one character of a count or length line; 0 on a framing error
	function bit take_number_char(logic [7:0] b, parse_state_e lf_state);
		logic [63:0] d;
		d = 64'(b - CH_ZERO);
		if (b >= CH_ZERO && b <= CH_NINE) begin
			if (value_acc > (LEN_CAP - d) / 10)
				value_acc = LEN_CAP;
			else
				value_acc = value_acc * 10 + d;
			have_digit = 1'b1;
			return 1'b1;
		end
		if (b == CH_MINUS && !neg_sign && !have_digit) begin
			neg_sign = 1'b1;
			return 1'b1;
		end
		if (b == CH_CR && have_digit) begin
			state = lf_state;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the parser by one byte and return the result it gives
	function rcp_result_t parse_byte(logic [7:0] b);
		rcp_result_t r;
		logic [15:0] idx;
		bit bad;
		r = '0;
		idx = elem_pos;
		bad = 1'b0;
		case (state)
			ST_WAIT_STAR, ST_SKIP: begin
				if (b == CH_STAR) begin
					clear_number();
					elem_count = '0;
					elem_pos = '0;
					state = ST_COUNT;
				end else if (state == ST_WAIT_STAR) begin
					bad = 1'b1;
				end
				idx = '0;
			end
			ST_COUNT: bad = !take_number_char(b, ST_COUNT_LF);
			ST_COUNT_LF: begin
				if (b != CH_LF || (neg_sign && value_acc != 0) || value_acc > lim_elems) begin
					bad = 1'b1;
				end else begin
					elem_count = value_acc[15:0];
					elem_pos = '0;
					clear_number();
					if (elem_count == 0) begin
						r.command_done = 1'b1;
						state = ST_WAIT_STAR;
					end else begin
						state = ST_MARKER;
					end
				end
			end
			ST_MARKER: begin
				if (b != CH_DOLLAR) begin
					bad = 1'b1;
				end else begin
					clear_number();
					state = ST_LENGTH;
				end
			end
			ST_LENGTH: bad = !take_number_char(b, ST_LENGTH_LF);
			ST_LENGTH_LF: begin
				if (b != CH_LF || (neg_sign && value_acc != 0) || value_acc > lim_bulk ||
						value_acc >= LEN_CAP) begin
					bad = 1'b1;
				end else begin
					bytes_left = value_acc;
					clear_number();
					state = (bytes_left != 0) ? ST_DATA : ST_TAIL_CR;
				end
			end
			ST_DATA: begin
				r.kind = KIND_PAYLOAD;
				r.payload_byte = b;
				bytes_left = bytes_left - 64'd1;
				if (bytes_left == 0)
					state = ST_TAIL_CR;
			end
			ST_TAIL_CR: begin
				if (b != CH_CR)
					bad = 1'b1;
				else
					state = ST_TAIL_LF;
			end
			ST_TAIL_LF: begin
				if (b != CH_LF) begin
					bad = 1'b1;
				end else begin
					r.element_done = 1'b1;
					elem_pos = elem_pos + 16'd1;
					if (elem_pos == elem_count) begin
						r.command_done = 1'b1;
						state = ST_WAIT_STAR;
					end else begin
						state = ST_MARKER;
					end
				end
			end
			default: bad = 1'b1;
		endcase
		// Drop the command and skip to the next '*'
		if (bad) begin
			clear_number();
			elem_count = '0;
			elem_pos = '0;
			bytes_left = '0;
			state = ST_SKIP;
			r = '0;
			r.kind = KIND_INVALID;
		end else begin
			r.element_index = idx;
			r.element_total = elem_count;
		end
		return r;
	endfunction

	function void note_byte(logic [7:0] b);
		owed_results.insert(owed_results.size(), parse_byte(b));
	endfunction

	function void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	function void check_result(rcp_result_t got);
		rcp_result_t want;
		if (owed_results.size() == 0) begin
			errors++;
			$display("%0t: result beat with nothing outstanding, expected none, actual kind %0d",
				$time, got.kind);
			return;
		end
		want = owed_results.pop_front();
		check_field("kind", want.kind, got.kind);
		check_field("payload_byte", want.payload_byte, got.payload_byte);
		check_field("element_index", want.element_index, got.element_index);
		check_field("element_done", want.element_done, got.element_done);
		check_field("command_done", want.command_done, got.command_done);
		check_field("element_total", want.element_total, got.element_total);
	endfunction

	function int pending();
		return owed_results.size();
	endfunction
endclass

module resp_command_parser_unit_tb;
	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [15:0] element_index;
	logic        element_done;
	logic        command_done;
	logic [15:0] element_total;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_wdata = '0;

	rcp_result_t out_beat;
	resp_result_board sb;

	// Bytes waiting to be offered, and the command under construction
	logic [7:0] stim_q[$];
	logic [7:0] cmd_q[$];
	int stim_total = 0;

	// Limits mirrored for the stimulus generator
	logic [15:0] cfg_max_elems = MAX_ELEMENTS_RST;
	logic [31:0] cfg_max_bulk = MAX_BULK_LENGTH_RST;

	// Sender and receiver pacing
	int burst_left = 0;
	int gap_left = 0;
	int beats_out = 0;
	int hold_left = 0;
	int style_left = 0;
	int ready_tick = 0;
	ready_style_e rx_style = RX_OPEN;

	resp_command_parser_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.payload_byte(payload_byte),
		.element_index(element_index),
		.element_done(element_done),
		.command_done(command_done),
		.element_total(element_total),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	assign out_beat = {kind, payload_byte, element_index, element_done, command_done,
		element_total};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer bytes in bursts; hold each beat until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'h00;
		end else begin
			if (in_valid && in_ready)
				sb.note_byte(in_byte);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (stim_q.size() != 0) begin
					in_valid <= 1'b1;
					in_byte <= stim_q.pop_front();
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Take result beats; stall in changing styles, with two long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			ready_tick++;
			if (out_valid && out_ready) begin
				sb.check_result(out_beat);
				beats_out++;
				if (beats_out == 300 || beats_out == 1100)
					hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					rx_style = ready_style_e'($urandom_range(0, 3));
					style_left = $urandom_range(16, 80);
				end
				style_left--;
				case (rx_style)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= (ready_tick % 4 != 3);
				endcase
			end
		end
	end

	task automatic write_register(logic idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, val);
		if (idx == CFG_MAX_ELEMENTS)
			cfg_max_elems = val[15:0];
		else
			cfg_max_bulk = val;
	endtask

	// Wait until every byte is taken and every result is back, then let the pipe settle
	task automatic drain();
		int waited;
		waited = 0;
		while (stim_q.size() != 0 || in_valid)
			@(posedge clk);
		while (sb.pending() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (6) @(posedge clk);
	endtask

	// Append one byte to the stimulus stream or to the command being built
	function automatic void add_stim_byte(logic [7:0] b);
		stim_q.insert(stim_q.size(), b);
	endfunction

	function automatic void add_cmd_byte(logic [7:0] b);
		cmd_q.insert(cmd_q.size(), b);
	endfunction

	function automatic void queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_stim_byte(s[i]);
		stim_total += s.len();
	endfunction

	// Append a decimal number, with a minus when neg is set and sometimes with leading zeros, then CRLF
	function automatic void add_line(logic [63:0] val, bit neg);
		logic [7:0] digits[$];
		int zeros;
		zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
		if (neg)
			add_cmd_byte(CH_MINUS);
		repeat (zeros) add_cmd_byte(CH_ZERO);
		do begin
			digits.push_front(CH_ZERO + 8'(val % 10));
			val = val / 10;
		end while (val != 0);
		foreach (digits[i])
			add_cmd_byte(digits[i]);
		add_cmd_byte(CH_CR);
		add_cmd_byte(CH_LF);
	endfunction

	// Build one command, mostly well formed, sometimes broken, and queue it
	task automatic queue_command();
		int elems, len, lmax, pick, pos;
		logic [63:0] val;
		bit neg, big;
		cmd_q.delete();
		big = 1'b0;
		// leading noise
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 4)) add_cmd_byte(8'($urandom_range(0, 255)));
		add_cmd_byte(CH_STAR);
		pick = $urandom_range(0, 24);
		neg = 1'b0;
		elems = $urandom_range(0, (cfg_max_elems < 4) ? cfg_max_elems : 4);
		val = 64'(elems);
		case (pick)
			0: begin
				val = 64'(cfg_max_elems) + 64'($urandom_range(1, 100));
				elems = 1;
				big = 1'b1;
			end
			1: begin
				neg = 1'b1;
				val = 64'($urandom_range(1, 9));
				elems = 1;
			end
			2: begin
				neg = 1'b1;
				val = 0;
				elems = 0;
			end
			3: begin
				if (cfg_max_elems <= 8) begin
					val = 64'(cfg_max_elems);
					elems = int'(cfg_max_elems);
				end
			end
			default: ;
		endcase
		// malformed count lines: empty, lone minus, minus after a digit, CR without LF
		case (pick)
			4: begin
				add_cmd_byte(CH_CR);
				add_cmd_byte(CH_LF);
			end
			5: begin
				add_cmd_byte(CH_MINUS);
				add_cmd_byte(CH_CR);
				add_cmd_byte(CH_LF);
			end
			6: begin
				add_cmd_byte(CH_ZERO + 8'd1);
				add_cmd_byte(CH_MINUS);
				add_cmd_byte(CH_ZERO + 8'd2);
				add_cmd_byte(CH_CR);
				add_cmd_byte(CH_LF);
			end
			7: begin
				add_cmd_byte(CH_ZERO + 8'd1);
				add_cmd_byte(CH_CR);
				add_cmd_byte(CH_DOLLAR);
			end
			default: add_line(val, neg);
		endcase
		if (pick >= 4 && pick <= 7)
			elems = 1;
		for (int e = 0; e < elems; e++) begin
			add_cmd_byte(CH_DOLLAR);
			pick = $urandom_range(0, 19);
			neg = 1'b0;
			lmax = (cfg_max_bulk < 6) ? int'(cfg_max_bulk) : 6;
			len = $urandom_range(0, lmax);
			val = 64'(len);
			case (pick)
				0: begin
					val = 64'(cfg_max_bulk) + 64'($urandom_range(1, 1000));
					len = 0;
					big = 1'b1;
				end
				1: begin
					val = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom);
					len = 0;
					big = 1'b1;
				end
				2: begin
					neg = 1'b1;
					val = 64'($urandom_range(1, 50));
					len = 0;
				end
				3: begin
					neg = 1'b1;
					val = 0;
					len = 0;
				end
				4: begin
					if (cfg_max_bulk <= 12) begin
						val = 64'(cfg_max_bulk);
						len = int'(cfg_max_bulk);
					end
				end
				default: ;
			endcase
			add_line(val, neg);
			repeat (len) add_cmd_byte(8'($urandom_range(0, 255)));
			add_cmd_byte(CH_CR);
			add_cmd_byte(CH_LF);
		end
		// break one command in six: replace, drop or cut short; keep large numbers intact
		if (!big && $urandom_range(0, 5) == 0) begin
			pos = $urandom_range(0, cmd_q.size() - 1);
			case ($urandom_range(0, 2))
				0: cmd_q[pos] = 8'($urandom_range(0, 255));
				1: cmd_q.delete(pos);
				default: begin
					while (cmd_q.size() > pos)
						cmd_q.delete(cmd_q.size() - 1);
				end
			endcase
		end
		foreach (cmd_q[i])
			add_stim_byte(cmd_q[i]);
		stim_total += cmd_q.size();
	endtask

	initial begin
		int budget[5];
		int mark;
		logic [15:0] lim_elems;
		logic [31:0] lim_bulk;
		sb = new();
		budget = '{400, 200, 400, 350, 300};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle error, skip, payload extremes, minus zero, lone minus, late minus
		queue_text("Ax*1\015\n$2\015\n");
		add_stim_byte(8'h00);
		add_stim_byte(8'hFF);
		stim_total += 2;
		queue_text("\015\n*-0\015\n*-\015*5-");

		// Random commands under several limit settings, reset values first
		for (int p = 0; p < 5; p++) begin
			if (p != 0) begin
				drain();
				case (p)
					1: begin
						lim_elems = 16'd0;
						lim_bulk = 32'd0;
					end
					2: begin
						lim_elems = 16'hFFFF;
						lim_bulk = 32'hFFFF_FFFF;
					end
					3: begin
						lim_elems = 16'd3;
						lim_bulk = 32'd5;
					end
					default: begin
						lim_elems = 16'($urandom_range(1, 6));
						lim_bulk = 32'($urandom_range(0, 10));
					end
				endcase
				write_register(CFG_MAX_ELEMENTS, {16'd0, lim_elems});
				write_register(CFG_MAX_BULK_LENGTH, lim_bulk);
			end
			mark = stim_total;
			while (stim_total - mark < budget[p])
				queue_command();
		end

		drain();
		if (sb.pending() != 0) begin
			$display("%0t: results missing, expected %0d more, actual 0", $time, sb.pending());
			sb.errors += sb.pending();
		end
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#1000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
